// File: rtl/core/stereo_channel_strip_pan_meter_unit_assert.svh
// assertion helpers for the channel strip
`ifndef STEREO_CHANNEL_STRIP_PAN_METER_UNIT_ASSERT_SVH
`define STEREO_CHANNEL_STRIP_PAN_METER_UNIT_ASSERT_SVH

// same-cycle implication
`define SCPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/scpm_pkg.sv
package scpm_pkg;

  // pi/2 in Q30 and 0.85 in Q0.16
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [16:0] DECAY_Q16   = 17'd55706;

  localparam int unsigned SINE_W = 17;

  // register indexes
  localparam logic [2:0] REG_TARGET_GAIN = 3'd0;
  localparam logic [2:0] REG_TARGET_PAN  = 3'd1;
  localparam logic [2:0] REG_MUTED       = 3'd2;
  localparam logic [2:0] REG_SOLOED      = 3'd3;
  localparam logic [2:0] REG_ANY_SOLO    = 3'd4;
  localparam logic [2:0] REG_SMOOTH_COEF = 3'd5;

  localparam logic [16:0] TARGET_GAIN_RST = 17'd65536;
  localparam logic [15:0] SMOOTH_COEF_RST = 16'd7760;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_GAIN = 12'b000000000010,
    S_PAN  = 12'b000000000100,
    S_IDX  = 12'b000000001000,
    S_RDL  = 12'b000000010000,
    S_RDR  = 12'b000000100000,
    S_GR   = 12'b000001000000,
    S_SL   = 12'b000010000000,
    S_SR   = 12'b000100000000,
    S_YR   = 12'b001000000000,
    S_MR   = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } scpm_state_e;

endpackage

// File: rtl/core/scpm_sine_rom.sv
module scpm_sine_rom import scpm_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr_i,
  output logic [SINE_W-1:0]                    data_o
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

  // quarter-wave sine in Q1.16, taylor series in Q30
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd8192) >> 14;
    if (r > 64'd65536) begin
      return 17'd65536;
    end
    return r[SINE_W-1:0];
  endfunction

  logic [SINE_W-1:0] sine_tbl [SINE_TABLE_DEPTH+1];
  logic [SINE_W-1:0] data_q;

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tbl
    assign sine_tbl[k] = sine_entry(k);
  end

  always_ff @(posedge clk_i) begin
    data_q <= sine_tbl[addr_i[AW-1:0]];
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/stereo_channel_strip_pan_meter_unit.sv
// an inaudible frame goes straight to the final step; an audible first frame of a block
// also smooths gain and pan ahead of the sample products, other audible frames do not,
// and an audible last frame adds a meter update; a new frame is accepted only when idle;
// one shared multiplier and one sine table read port serve all products in turn
// reset: asynchronous, active low; registers to their defaults, gains, peaks, meters zero
`include "stereo_channel_strip_pan_meter_unit_assert.svh"

module stereo_channel_strip_pan_meter_unit import scpm_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int SAMPLE_WIDTH     = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right_i,
  input  logic                           first_of_block_i,
  input  logic                           last_of_block_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_o,
  output logic [SAMPLE_WIDTH-1:0]        meter_left_o,
  output logic [SAMPLE_WIDTH-1:0]        meter_right_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int MA = ((SW > 18) ? SW : 18) + 1;
  localparam int MB = 19;
  localparam int PW = MA + MB;
  localparam int RW = PW - 16;
  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
  localparam logic [SW-1:0] PEAK_MAX = SW'(64'd1 << (SW - 1));
  localparam logic [IW-1:0] DEPTH_IDX = IW'(SINE_TABLE_DEPTH);

  // configuration registers
  logic [16:0] tgain_q;
  logic [15:0] tpan_q;
  logic        muted_q, soloed_q, any_solo_q;
  logic [15:0] coef_q;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgain_q    <= TARGET_GAIN_RST;
      tpan_q     <= '0;
      muted_q    <= 1'b0;
      soloed_q   <= 1'b0;
      any_solo_q <= 1'b0;
      coef_q     <= SMOOTH_COEF_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_TARGET_GAIN: tgain_q    <= pwdata[16:0];
        REG_TARGET_PAN:  tpan_q     <= pwdata[15:0];
        REG_MUTED:       muted_q    <= pwdata[0];
        REG_SOLOED:      soloed_q   <= pwdata[0];
        REG_ANY_SOLO:    any_solo_q <= pwdata[0];
        REG_SMOOTH_COEF: coef_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TARGET_GAIN: prdata = {15'd0, tgain_q};
      REG_TARGET_PAN:  prdata = {16'd0, tpan_q};
      REG_MUTED:       prdata = {31'd0, muted_q};
      REG_SOLOED:      prdata = {31'd0, soloed_q};
      REG_ANY_SOLO:    prdata = {31'd0, any_solo_q};
      REG_SMOOTH_COEF: prdata = {16'd0, coef_q};
      default:         prdata = '0;
    endcase
  end

  // sequencer and datapath state
  scpm_state_e state_q, state_d;

  logic signed [SW-1:0] xl_q, xr_q;
  logic                 first_q, last_q, aud_q;
  logic [16:0]          sgain_q;
  logic [15:0]          span_q;
  logic [17:0]          lgain_q, rgain_q;
  logic [SW-1:0]        peak_l_q, peak_r_q;
  logic [SW-1:0]        meter_l_q, meter_r_q;
  logic signed [SW-1:0] yl_q, yr_q;
  logic signed [PW-1:0] prod_q;

  logic                 out_valid_q;
  logic signed [SW-1:0] out_l_q, out_r_q;
  logic [SW-1:0]        out_ml_q, out_mr_q;

  logic audible, in_accept, out_free, fin_go;
  assign audible   = !muted_q && (!any_solo_q || soloed_q);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fin_go    = (state_q == S_FIN) && out_free;

  // shared multiplier with rounding shift
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [17:0]   gdiff;
  logic signed [16:0]   pdiff;
  logic signed [PW-1:0] rnd_full;
  logic signed [RW-1:0] rnd;

  assign gdiff    = $signed({1'b0, sgain_q}) - $signed({1'b0, tgain_q});
  assign pdiff    = $signed({span_q[15], span_q}) - $signed({tpan_q[15], tpan_q});
  assign rnd_full = (prod_q + ROUND_HALF) >>> 16;
  assign rnd      = rnd_full[RW-1:0];

  // sine table addressing from the smoothed pan
  logic [15:0]      pan_u;
  logic [16+IW-1:0] idx_full;
  logic [IW-1:0]    idx, rom_addr;
  logic [SINE_W-1:0] rom_data;

  assign pan_u    = {~span_q[15], span_q[14:0]};
  assign idx_full = {{IW{1'b0}}, pan_u} * (16 + IW)'(SINE_TABLE_DEPTH);
  assign idx      = idx_full[16 +: IW];
  assign rom_addr = (state_q == S_RDL) ? (DEPTH_IDX - idx) : idx;

  scpm_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GAIN: begin
        mul_a = MA'(gdiff);
        mul_b = $signed({3'b000, coef_q});
      end
      S_PAN: begin
        mul_a = MA'(pdiff);
        mul_b = $signed({3'b000, coef_q});
      end
      S_RDR, S_GR: begin
        mul_a = $signed({{(MA-17){1'b0}}, sgain_q});
        mul_b = $signed({2'b00, rom_data});
      end
      S_SL: begin
        mul_a = MA'(xl_q);
        mul_b = $signed({1'b0, lgain_q});
      end
      S_SR: begin
        mul_a = MA'(xr_q);
        mul_b = $signed({1'b0, rgain_q});
      end
      S_YR: begin
        mul_a = $signed({{(MA-SW){1'b0}}, meter_l_q});
        mul_b = $signed({2'b00, DECAY_Q16});
      end
      S_MR, S_FIN: begin
        mul_a = $signed({{(MA-SW){1'b0}}, meter_r_q});
        mul_b = $signed({2'b00, DECAY_Q16});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mul_a) * PW'(mul_b);
  end

  // saturated sample and its magnitude
  logic signed [SW-1:0] y_sat;
  logic [SW-1:0]        y_abs;
  logic [SW-1:0]        dec_v, meter_l_new, meter_r_new;

  always_comb begin
    if (rnd > SAT_HI) begin
      y_sat = SAT_HI[SW-1:0];
    end else if (rnd < SAT_LO) begin
      y_sat = SAT_LO[SW-1:0];
    end else begin
      y_sat = rnd[SW-1:0];
    end
  end

  assign y_abs       = y_sat[SW-1] ? SW'(-y_sat) : SW'(y_sat);
  assign dec_v       = rnd[SW-1:0];
  assign meter_l_new = (peak_l_q > dec_v) ? peak_l_q : dec_v;
  assign meter_r_new = (peak_r_q > dec_v) ? peak_r_q : dec_v;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (!audible) begin
            state_d = S_FIN;
          end else if (first_of_block_i) begin
            state_d = S_GAIN;
          end else begin
            state_d = S_SL;
          end
        end
      end
      S_GAIN: state_d = S_PAN;
      S_PAN:  state_d = S_IDX;
      S_IDX:  state_d = S_RDL;
      S_RDL:  state_d = S_RDR;
      S_RDR:  state_d = S_GR;
      S_GR:   state_d = S_SL;
      S_SL:   state_d = S_SR;
      S_SR:   state_d = S_YR;
      S_YR:   state_d = last_q ? S_MR : S_FIN;
      S_MR:   state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // frame payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      xl_q    <= in_left_i;
      xr_q    <= in_right_i;
      first_q <= first_of_block_i;
      last_q  <= last_of_block_i;
      aud_q   <= audible;
    end
    if (in_accept) begin
      yl_q <= '0;
      yr_q <= '0;
    end else if (state_q == S_SR) begin
      yl_q <= y_sat;
    end else if (state_q == S_YR) begin
      yr_q <= y_sat;
    end
  end

  // smoothed gain and pan, channel gains, peaks and meters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sgain_q   <= '0;
      span_q    <= '0;
      lgain_q   <= '0;
      rgain_q   <= '0;
      peak_l_q  <= '0;
      peak_r_q  <= '0;
      meter_l_q <= '0;
      meter_r_q <= '0;
    end else begin
      case (state_q)
        S_PAN: sgain_q <= tgain_q + rnd[16:0];
        S_IDX: span_q  <= tpan_q + rnd[15:0];
        S_GR:  lgain_q <= rnd[17:0];
        S_SL: begin
          if (first_q) begin
            rgain_q <= rnd[17:0];
          end
        end
        S_SR: begin
          if (y_abs > peak_l_q) begin
            peak_l_q <= y_abs;
          end
        end
        S_YR: begin
          if (y_abs > peak_r_q) begin
            peak_r_q <= y_abs;
          end
        end
        S_MR: meter_l_q <= meter_l_new;
        S_FIN: begin
          if (out_free && last_q) begin
            if (aud_q) begin
              meter_r_q <= meter_r_new;
            end
            peak_l_q <= '0;
            peak_r_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_l_q  <= yl_q;
      out_r_q  <= yr_q;
      out_ml_q <= meter_l_q;
      out_mr_q <= (last_q && aud_q) ? meter_r_new : meter_r_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_left_o    = out_l_q;
  assign out_right_o   = out_r_q;
  assign meter_left_o  = out_ml_q;
  assign meter_right_o = out_mr_q;

  `SCPM_ASSERT_NXT(a_busy_after_accept, in_accept, in_stall_o,
                   "sequencer not busy after a word was accepted")
  `SCPM_ASSERT_IMP(a_smooth_only_audible_first, state_q == S_GAIN, first_q && aud_q,
                   "smoothing started on a frame that is not an audible first frame")
  `SCPM_ASSERT_IMP(a_peak_range, 1'b1, (peak_l_q <= PEAK_MAX) && (peak_r_q <= PEAK_MAX),
                   "block peak beyond full scale")
  `SCPM_ASSERT_IMP(a_result_from_fin, $rose(out_valid_q), $past(state_q == S_FIN),
                   "result word raised outside the final step")

endmodule
